// ===== rtl/tcp_pkg.sv =====
// Package for the tilt complementary PID controller.
// Holds register codes, reset values, step codes and shared helpers.
// No dependencies.
package tcp_pkg;

    typedef enum logic [2:0] {
        REG_GYRO_X_OFS  = 3'd0,
        REG_ACCEL_Y_OFS = 3'd1,
        REG_ACCEL_Z_OFS = 3'd2,
        REG_TARGET      = 3'd3,
        REG_PROP_GAIN   = 3'd4,
        REG_INT_GAIN    = 3'd5,
        REG_DERIV_GAIN  = 3'd6,
        REG_FALL_THR    = 3'd7
    } reg_idx_t;

    localparam logic [15:0] RST_GYRO_X_OFS  = 16'hFF78;  // -136
    localparam logic [15:0] RST_ACCEL_Y_OFS = 16'd527;
    localparam logic [15:0] RST_ACCEL_Z_OFS = 16'hFEC2;  // -318
    localparam logic [15:0] RST_TARGET      = 16'hFD80;  // -640, -2.5 deg
    localparam logic [17:0] RST_PROP_GAIN   = 18'd15872;
    localparam logic [17:0] RST_INT_GAIN    = 18'd153600;
    localparam logic [17:0] RST_DERIV_GAIN  = 18'd77;
    localparam logic [14:0] RST_FALL_THR    = 15'd9000;

    // 180 degrees in Q16.16
    localparam logic signed [63:0] DEG180 = 64'sd11796480;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_ISSUE,
        ST_WAIT,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        SP_RATE_MUL,
        SP_RATE_DIV,
        SP_PREV_MUL,
        SP_RDT_MUL,
        SP_RDT_K_MUL,
        SP_ACC_MUL,
        SP_NUM_DIV,
        SP_P_MUL,
        SP_I_MUL,
        SP_IDT_MUL,
        SP_I_DIV,
        SP_D_MUL,
        SP_D_K_MUL,
        SP_D_DIV
    } step_t;

    // Arctangent of 2^-i in Q16.16 degrees
    function automatic logic [31:0] atan_deg(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0:  r = 32'd2949120;
                5'd1:  r = 32'd1740967;
                5'd2:  r = 32'd919880;
                5'd3:  r = 32'd466945;
                5'd4:  r = 32'd234378;
                5'd5:  r = 32'd117303;
                5'd6:  r = 32'd58666;
                5'd7:  r = 32'd29335;
                5'd8:  r = 32'd14668;
                5'd9:  r = 32'd7334;
                5'd10: r = 32'd3667;
                5'd11: r = 32'd1833;
                5'd12: r = 32'd917;
                5'd13: r = 32'd458;
                5'd14: r = 32'd229;
                5'd15: r = 32'd115;
                5'd16: r = 32'd57;
                5'd17: r = 32'd29;
                5'd18: r = 32'd14;
                5'd19: r = 32'd7;
                5'd20: r = 32'd4;
                5'd21: r = 32'd2;
                5'd22: r = 32'd1;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

    // Magnitude of a signed 64-bit value
    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // Symmetric clamp to +-lim
    function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
                                                   input logic signed [63:0] lim);
        logic signed [63:0] r;
        begin
            if (v > lim)
                r = lim;
            else if (v < -lim)
                r = -lim;
            else
                r = v;
            return r;
        end
    endfunction

endpackage

// ===== rtl/tcp_cordic.sv =====
// Iterative CORDIC vectoring unit: atan2 in Q16.16 degrees, one iteration a cycle.
// Depends on tcp_pkg (arctangent table, clamp).
module tcp_cordic #(
    parameter int ITER = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] y_in,
    input  logic signed [15:0] x_in,
    output logic               done,
    output logic signed [31:0] angle
);
    import tcp_pkg::*;

    localparam int CW = $clog2(ITER + 1);

    logic signed [32:0] x_reg, y_reg, x_next, y_next;
    logic signed [31:0] z_reg, z_next;
    logic [CW-1:0]      cnt_reg;
    logic               busy_reg, done_reg, zero_reg;
    logic signed [32:0] xs, ys, dx, dy;
    logic [4:0]         idx;

    assign xs  = 33'(x_in) <<< 14;
    assign ys  = 33'(y_in) <<< 14;
    assign dx  = x_reg >>> cnt_reg;
    assign dy  = y_reg >>> cnt_reg;
    assign idx = 5'(cnt_reg);

    // Pre-rotate into the right half plane, then one micro-rotation a cycle
    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (start)
        begin
            x_next = xs;
            y_next = ys;
            z_next = '0;
            if (xs < 0)
            begin
                if (ys >= 0)
                begin
                    x_next = ys;
                    y_next = -xs;
                    z_next = 32'sd5898240;
                end
                else
                begin
                    x_next = -ys;
                    y_next = xs;
                    z_next = -32'sd5898240;
                end
            end
        end
        else if (busy_reg && cnt_reg != CW'(ITER))
        begin
            if (y_reg >= 0)
            begin
                x_next = x_reg + dy;
                y_next = y_reg - dx;
                z_next = z_reg + $signed(atan_deg(idx));
            end
            else
            begin
                x_next = x_reg - dy;
                y_next = y_reg + dx;
                z_next = z_reg - $signed(atan_deg(idx));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        if (start)
            zero_reg <= (x_in == 0) && (y_in == 0);
    end

    // Iteration count and completion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CW'(ITER))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign done  = done_reg;
    assign angle = zero_reg ? 32'sd0 : 32'(clamp64(64'(z_reg), DEG180));

endmodule

// ===== rtl/tcp_mul.sv =====
// Bit-serial shift-add multiplier, unsigned 64 x 32, one multiplier bit a cycle.
// No dependencies.
module tcp_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [63:0] prod
);
    logic [63:0] a_reg, acc_reg;
    logic [31:0] b_reg;
    logic        busy_reg, done_reg;

    // Shift the multiplicand up and the multiplier down, add on each set bit
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg && b_reg != '0)
        begin
            if (b_reg[0])
                acc_reg <= acc_reg + a_reg;
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && b_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== rtl/tcp_div.sv =====
// Bit-serial restoring divider, unsigned 64 / 32, one quotient bit a cycle.
// No dependencies.
module tcp_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] n,
    input  logic [31:0] d,
    output logic        done,
    output logic [63:0] quot
);
    logic [63:0] q_reg;
    logic [31:0] rem_reg, d_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [32:0] trial, diff;

    assign trial = {rem_reg, q_reg[63]};
    assign diff  = trial - {1'b0, d_reg};

    // Shift the dividend in, subtract where the remainder allows
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= n;
            d_reg   <= d;
            rem_reg <= '0;
        end
        else if (busy_reg && cnt_reg != 7'd64)
        begin
            if (!diff[32])
            begin
                rem_reg <= diff[31:0];
                q_reg   <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[31:0];
                q_reg   <= {q_reg[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 7'd64)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ===== rtl/tilt_complementary_pid_step.sv =====
// Tilt complementary filter and PID step: one IMU item in, one drive item out.
// Each item runs a CORDIC pass, then ten multiplies and four divides in turn on the multiplier
// and divider, then loads the output register. One item at a time, the next accepted once the
// result is loaded; a stalled result holds the next item in ST_FINISH. Items whose accel and
// gyro fields are all zero are dropped at once. Reset (rst_n, asynchronous, active low)
// restores register defaults and zeros state. Depends on tcp_pkg, cordic, mul, div.
module tilt_complementary_pid_step #(
    parameter int INTEGRAL_LIMIT    = 600,
    parameter int MOTOR_LIMIT       = 1000,
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // accel_y[15:0], accel_z[31:16], gyro_x[47:32], elapsed_ms[57:48], zero
    input  logic [63:0] s_axis_tdata,
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // motor_power[10:0], forward[11], pwm_compare[21:12], fallen[22], tilt_angle[47:23]
    output logic [47:0] m_axis_tdata
);
    import tcp_pkg::*;

    localparam logic signed [63:0] ILIM   = 64'(INTEGRAL_LIMIT) * 64'sd65536;
    localparam int                 MLIM_I = (MOTOR_LIMIT < 1023) ? MOTOR_LIMIT : 1023;
    localparam logic [9:0]         MLIM   = 10'(MLIM_I);

    // configuration registers
    logic [15:0] gyro_ofs_reg, ay_ofs_reg, az_ofs_reg, target_reg;
    logic [17:0] kp_reg, ki_reg, kd_reg;
    logic [14:0] thr_reg;
    logic        cfg_wr;
    reg_idx_t    cfg_idx;

    assign pready = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;

    // Write registers on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_ofs_reg <= RST_GYRO_X_OFS;
            ay_ofs_reg   <= RST_ACCEL_Y_OFS;
            az_ofs_reg   <= RST_ACCEL_Z_OFS;
            target_reg   <= RST_TARGET;
            kp_reg       <= RST_PROP_GAIN;
            ki_reg       <= RST_INT_GAIN;
            kd_reg       <= RST_DERIV_GAIN;
            thr_reg      <= RST_FALL_THR;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_GYRO_X_OFS:  gyro_ofs_reg <= pwdata[15:0];
                REG_ACCEL_Y_OFS: ay_ofs_reg   <= pwdata[15:0];
                REG_ACCEL_Z_OFS: az_ofs_reg   <= pwdata[15:0];
                REG_TARGET:      target_reg   <= pwdata[15:0];
                REG_PROP_GAIN:   kp_reg       <= pwdata[17:0];
                REG_INT_GAIN:    ki_reg       <= pwdata[17:0];
                REG_DERIV_GAIN:  kd_reg       <= pwdata[17:0];
                REG_FALL_THR:    thr_reg      <= pwdata[14:0];
                default:         thr_reg      <= thr_reg;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (cfg_idx)
            REG_GYRO_X_OFS:  prdata = {16'd0, gyro_ofs_reg};
            REG_ACCEL_Y_OFS: prdata = {16'd0, ay_ofs_reg};
            REG_ACCEL_Z_OFS: prdata = {16'd0, az_ofs_reg};
            REG_TARGET:      prdata = {16'd0, target_reg};
            REG_PROP_GAIN:   prdata = {14'd0, kp_reg};
            REG_INT_GAIN:    prdata = {14'd0, ki_reg};
            REG_DERIV_GAIN:  prdata = {14'd0, kd_reg};
            REG_FALL_THR:    prdata = {17'd0, thr_reg};
            default:         prdata = '0;
        endcase
    end

    // input item decode
    logic               in_acc, in_zero;
    logic signed [15:0] ay_c, az_c, gx_c;
    logic [16:0]        ay_mag;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign in_zero = s_axis_tdata[47:0] == '0;
    assign ay_c    = s_axis_tdata[15:0] - ay_ofs_reg;
    assign az_c    = s_axis_tdata[31:16] - az_ofs_reg;
    assign gx_c    = s_axis_tdata[47:32] - gyro_ofs_reg;
    assign ay_mag  = ay_c[15] ? 17'(-17'(ay_c)) : 17'(ay_c);

    // sequencer state and data path
    state_t             state_reg, state_next;
    step_t              step_reg, step_next;
    logic signed [15:0] gx_reg;
    logic [9:0]         dt_reg;
    logic               fell_reg;
    logic signed [31:0] acc_reg, prev_reg, integ_reg, cur_reg, err_reg;
    logic signed [9:0]  rate_reg;
    logic signed [63:0] t_reg, num_reg, tot_reg;
    logic               op_neg_reg, op_div_reg;
    logic               out_valid_reg;
    logic [47:0]        out_data_reg;

    logic               cordic_start, cordic_done;
    logic signed [31:0] cordic_angle;
    logic               mul_start, mul_done, div_start, div_done, unit_done;
    logic [63:0]        mul_p, div_q, res_mag;
    logic signed [63:0] sres;
    logic [63:0]        op_a;
    logic [31:0]        op_b;
    logic               op_neg, op_div;
    logic [10:0]        den;
    logic signed [32:0] diff_c;
    logic signed [63:0] cur_c, err_c, int_c, p_c;
    logic [63:0]        tot_mag;
    logic [9:0]         motor_mag;
    logic signed [10:0] motor_c;
    logic [9:0]         pwm_c;
    logic               slot_free, out_load;

    assign den       = 11'd750 + 11'(dt_reg);
    assign diff_c    = 33'(cur_reg) - 33'(prev_reg);
    assign unit_done = mul_done || div_done;
    assign res_mag   = op_div_reg ? div_q : mul_p;
    assign sres      = op_neg_reg ? -$signed(res_mag) : $signed(res_mag);

    // filter result, tilt error and clamped integral
    assign cur_c = clamp64(sres, DEG180);
    assign err_c = cur_c - (64'($signed(target_reg)) <<< 8);
    assign int_c = clamp64(64'(integ_reg) + err_c, ILIM);
    assign p_c   = op_neg_reg ? -$signed(res_mag >> 8) : $signed(res_mag >> 8);

    // Select the operands of the current step
    always_comb
    begin
        op_a   = '0;
        op_b   = '0;
        op_neg = 1'b0;
        op_div = 1'b0;
        case (step_reg)
            SP_RATE_MUL:
            begin
                op_a = 64'({~gx_reg[15], gx_reg[14:0]});
                op_b = 32'd500;
            end
            SP_RATE_DIV:
            begin
                op_a   = mag64(t_reg);
                op_b   = 32'd65535;
                op_neg = t_reg[63];
                op_div = 1'b1;
            end
            SP_PREV_MUL:
            begin
                op_a   = mag64(64'(prev_reg));
                op_b   = 32'd750;
                op_neg = prev_reg[31];
            end
            SP_RDT_MUL:
            begin
                op_a   = mag64(64'(rate_reg));
                op_b   = 32'(dt_reg);
                op_neg = rate_reg[9];
            end
            SP_RDT_K_MUL:
            begin
                op_a   = mag64(t_reg);
                op_b   = 32'd49152;
                op_neg = t_reg[63];
            end
            SP_ACC_MUL:
            begin
                op_a   = mag64(64'(acc_reg));
                op_b   = 32'(dt_reg);
                op_neg = acc_reg[31];
            end
            SP_NUM_DIV:
            begin
                op_a   = mag64(num_reg) + 64'(den >> 1);
                op_b   = 32'(den);
                op_neg = num_reg[63];
                op_div = 1'b1;
            end
            SP_P_MUL:
            begin
                op_a   = mag64(64'(err_reg));
                op_b   = 32'(kp_reg);
                op_neg = err_reg[31];
            end
            SP_I_MUL:
            begin
                op_a   = mag64(64'(integ_reg));
                op_b   = 32'(ki_reg);
                op_neg = integ_reg[31];
            end
            SP_IDT_MUL:
            begin
                op_a   = mag64(t_reg);
                op_b   = 32'(dt_reg);
                op_neg = t_reg[63];
            end
            SP_I_DIV:
            begin
                op_a   = mag64(t_reg);
                op_b   = 32'd256000;
                op_neg = t_reg[63];
                op_div = 1'b1;
            end
            SP_D_MUL:
            begin
                op_a   = mag64(64'(diff_c));
                op_b   = 32'(kd_reg);
                op_neg = diff_c[32];
            end
            SP_D_K_MUL:
            begin
                op_a   = mag64(t_reg);
                op_b   = 32'd1000;
                op_neg = t_reg[63];
            end
            SP_D_DIV:
            begin
                op_a   = mag64(t_reg);
                op_b   = {14'd0, dt_reg, 8'd0};
                op_neg = t_reg[63];
                op_div = 1'b1;
            end
            default:
            begin
                op_a = '0;
            end
        endcase
    end

    // drive from the summed terms
    assign tot_mag   = mag64(tot_reg) >> 16;
    assign motor_mag = (fell_reg) ? 10'd0 : ((tot_mag > 64'(MLIM)) ? MLIM : tot_mag[9:0]);
    assign motor_c   = tot_reg[63] ? -$signed({1'b0, motor_mag}) : $signed({1'b0, motor_mag});
    assign pwm_c     = (motor_mag > 10'd1000) ? 10'd0 : 10'd1000 - motor_mag;
    assign slot_free = !out_valid_reg || m_axis_tready;
    assign out_load  = (state_reg == ST_FINISH) && slot_free;

    // Next state and unit starts
    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        cordic_start = 1'b0;
        mul_start    = 1'b0;
        div_start    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && !in_zero)
                begin
                    cordic_start = 1'b1;
                    state_next   = ST_CORDIC;
                end
            end
            ST_CORDIC:
            begin
                if (cordic_done)
                begin
                    step_next  = SP_RATE_MUL;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                mul_start  = !op_div;
                div_start  = op_div;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (unit_done)
                begin
                    if (step_reg == SP_D_DIV)
                        state_next = ST_FINISH;
                    else
                    begin
                        step_next  = step_t'(step_reg + 1'b1);
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= SP_RATE_MUL;
            prev_reg      <= '0;
            integ_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (state_reg == ST_WAIT && unit_done && step_reg == SP_NUM_DIV)
                integ_reg <= 32'(int_c);
            if (out_load)
            begin
                prev_reg      <= fell_reg ? 32'sd0 : cur_reg;
                if (fell_reg)
                    integ_reg <= '0;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Latch the item, then fold each unit result into the working values
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_acc)
        begin
            gx_reg   <= gx_c;
            dt_reg   <= (s_axis_tdata[57:48] == '0) ? 10'd1 : s_axis_tdata[57:48];
            fell_reg <= ay_mag > 17'(thr_reg);
        end
        if (state_reg == ST_CORDIC && cordic_done)
            acc_reg <= cordic_angle;
        if (state_reg == ST_ISSUE)
        begin
            op_neg_reg <= op_neg;
            op_div_reg <= op_div;
        end
        if (state_reg == ST_WAIT && unit_done)
        begin
            case (step_reg)
                SP_RATE_MUL:  t_reg    <= sres - 64'sd16383750;
                SP_RATE_DIV:  rate_reg <= sres[9:0];
                SP_PREV_MUL:  num_reg  <= sres;
                SP_RDT_K_MUL: num_reg  <= num_reg + sres;
                SP_ACC_MUL:   num_reg  <= num_reg + sres;
                SP_NUM_DIV:
                begin
                    cur_reg <= 32'(cur_c);
                    err_reg <= 32'(err_c);
                end
                SP_P_MUL:     tot_reg  <= p_c;
                SP_I_DIV:     tot_reg  <= tot_reg + sres;
                SP_D_DIV:     tot_reg  <= tot_reg - sres;
                default:      t_reg    <= sres;
            endcase
        end
        if (out_load)
            out_data_reg <= {cur_reg[24:0], fell_reg, pwm_c, !tot_reg[63] && motor_mag != 0,
                             motor_c};
    end

    tcp_cordic #(
        .ITER (CORDIC_ITERATIONS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .y_in  (ay_c),
        .x_in  (az_c),
        .done  (cordic_done),
        .angle (cordic_angle)
    );

    tcp_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (op_a),
        .b     (op_b),
        .done  (mul_done),
        .prod  (mul_p)
    );

    tcp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n     (op_a),
        .d     (op_b),
        .done  (div_done),
        .quot  (div_q)
    );

    assign s_axis_tready = state_reg == ST_IDLE;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== rtl/tcp_chk.sv =====
// Port-level checker for the tilt controller, bound to the top level.
// Depends on the top level's port list only.
module tcp_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);
    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // forward only with a positive drive
    a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[11] |-> !m_axis_tdata[10] && m_axis_tdata[10:0] != 11'd0)
        else $error("forward without positive drive");

    // a fall zeros the drive and opens the compare fully
    a_fall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[22] |->
            m_axis_tdata[10:0] == 11'd0 && m_axis_tdata[21:12] == 10'd1000)
        else $error("fall did not zero the drive");

    // stay ready while idle and nothing is offered
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready && !s_axis_tvalid |=> s_axis_tready)
        else $error("accept state lost while idle");

endmodule

bind tilt_complementary_pid_step tcp_chk u_tcp_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
